FILE: rtl/pes_to_ts_packetizer_defines.svh
// ----------------------------------------------------------------------------
// pes_to_ts_packetizer_defines
// Assertion macros shared by the packetizer checker.
// ----------------------------------------------------------------------------
`ifndef PES_TO_TS_PACKETIZER_DEFINES_SVH
`define PES_TO_TS_PACKETIZER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PTSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PTSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ptsp_pkg.sv
// ----------------------------------------------------------------------------
// ptsp_pkg
// Types and constants of the PES to transport stream packetizer.
// ----------------------------------------------------------------------------
package ptsp_pkg;

    localparam int PID_W       = 13;
    localparam int WORD_W      = 64;
    localparam int OUT_TDATA_W = 72;
    localparam int BODY_LEN    = 184;

    localparam logic [7:0] SYNC_BYTE    = 8'h47;
    localparam logic [7:0] STUFF_BYTE   = 8'hFF;
    localparam logic [7:0] ZERO_BYTE    = 8'h00;
    localparam logic [7:0] START_PREFIX = 8'h01;
    localparam logic [2:0] AUDIO_ID_TOP = 3'b110;

    localparam logic [3:0] AFC_PAYLOAD       = 4'h1;
    localparam logic [3:0] AFC_ADAPT_PAYLOAD = 4'h3;

    localparam logic [7:0] PKT_LEN_B   = 8'd188;
    localparam logic [7:0] BODY_LEN_B  = 8'd184;
    localparam logic [7:0] SPLIT_COUNT = 8'd183;
    localparam logic [7:0] SPLIT_A_LEN = 8'd182;
    localparam logic [7:0] SPLIT_B_LEN = 8'd1;
    localparam logic [7:0] ADAPT_BASE  = 8'd183;
    localparam logic [7:0] LAST_POS    = 8'd187;

    localparam logic [7:0] POS_SYNC     = 8'd0;
    localparam logic [7:0] POS_HDR1     = 8'd1;
    localparam logic [7:0] POS_HDR2     = 8'd2;
    localparam logic [7:0] POS_HDR3     = 8'd3;
    localparam logic [7:0] POS_AF_LEN   = 8'd4;
    localparam logic [7:0] POS_AF_FLAGS = 8'd5;

    localparam logic [3:0] BV_FULL = 4'd8;
    localparam logic [3:0] BV_TAIL = 4'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PUSH,
        ST_FULL,
        ST_FULL_W,
        ST_DRAIN,
        ST_FL1,
        ST_FL1_W,
        ST_FL2,
        ST_FL2_W
    } ptsp_state_t;

    typedef enum logic [1:0] {
        PK_FULL,
        PK_FLUSH,
        PK_SPLIT_A,
        PK_SPLIT_B
    } ptsp_pkt_kind_t;

    typedef struct packed {
        logic           win_write;
        logic           push;
        logic           clr_count;
        logic           set_usf;
        logic           clr_usf;
        logic           pkt_start;
        ptsp_pkt_kind_t pkt_kind;
        logic           pkt_last;
    } ptsp_cmd_t;

    typedef struct packed {
        logic fill_three;
        logic fill_zero;
        logic count_zero;
        logic count_split;
        logic start_code;
        logic gen_busy;
    } ptsp_stat_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       eop;
        logic       last;
    } ptsp_byte_t;

endpackage

FILE: rtl/ptsp_ctrl.sv
// ----------------------------------------------------------------------------
// ptsp_ctrl
// Sequencer: window check, payload push, full and flush packet requests.
// ----------------------------------------------------------------------------
module ptsp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_action,
    output logic                in_ready,
    input  ptsp_pkg::ptsp_stat_t stat,
    output ptsp_pkg::ptsp_cmd_t  cmd
);
    import ptsp_pkg::*;

    ptsp_state_t state_reg;
    ptsp_state_t state_next;
    logic        eos_reg;
    logic        eos_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            eos_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            eos_reg   <= eos_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        eos_next   = eos_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    eos_next = in_action;
                    if (in_action)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        cmd.win_write = 1'b1;
                        if (stat.fill_three)
                        begin
                            state_next = ST_CHECK;
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                if (stat.start_code)
                begin
                    if (!stat.count_zero)
                    begin
                        state_next = ST_FL1;
                    end
                    else
                    begin
                        cmd.set_usf = 1'b1;
                        state_next  = ST_PUSH;
                    end
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                cmd.push = 1'b1;
                if (stat.count_split)
                begin
                    state_next = ST_FULL;
                end
                else
                begin
                    state_next = eos_reg ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_FULL:
            begin
                cmd.pkt_start = 1'b1;
                cmd.pkt_kind  = PK_FULL;
                // while draining, later window bytes will still produce a packet
                cmd.pkt_last  = !eos_reg || stat.fill_zero;
                state_next    = ST_FULL_W;
            end
            ST_FULL_W:
            begin
                if (!stat.gen_busy)
                begin
                    cmd.clr_count = 1'b1;
                    cmd.clr_usf   = 1'b1;
                    state_next    = eos_reg ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.fill_zero)
                begin
                    state_next = ST_PUSH;
                end
                else if (!stat.count_zero)
                begin
                    state_next = ST_FL1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FL1:
            begin
                cmd.pkt_start = 1'b1;
                cmd.pkt_kind  = stat.count_split ? PK_SPLIT_A : PK_FLUSH;
                cmd.pkt_last  = !stat.count_split;
                state_next    = ST_FL1_W;
            end
            ST_FL1_W:
            begin
                if (!stat.gen_busy)
                begin
                    if (stat.count_split)
                    begin
                        state_next = ST_FL2;
                    end
                    else
                    begin
                        cmd.clr_count = 1'b1;
                        if (!eos_reg)
                        begin
                            cmd.set_usf = 1'b1;
                            state_next  = ST_PUSH;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_FL2:
            begin
                cmd.pkt_start = 1'b1;
                cmd.pkt_kind  = PK_SPLIT_B;
                cmd.pkt_last  = 1'b1;
                cmd.clr_usf   = 1'b1;
                state_next    = ST_FL2_W;
            end
            ST_FL2_W:
            begin
                if (!stat.gen_busy)
                begin
                    cmd.clr_count = 1'b1;
                    if (!eos_reg)
                    begin
                        cmd.set_usf = 1'b1;
                        state_next  = ST_PUSH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/ptsp_dpath.sv
// ----------------------------------------------------------------------------
// ptsp_dpath
// Lookahead window, payload RAM, counters and the byte-wide packet generator.
// ----------------------------------------------------------------------------
module ptsp_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [7:0]                   in_byte,
    input  logic                         cfg_wr_en,
    input  logic [ptsp_pkg::PID_W-1:0]   cfg_wr_data,
    input  ptsp_pkg::ptsp_cmd_t          cmd,
    output ptsp_pkg::ptsp_stat_t         stat,
    output ptsp_pkg::ptsp_byte_t         byte_out,
    input  logic                         byte_ready
);
    import ptsp_pkg::*;

    logic [7:0]       win_reg [4];
    logic [2:0]       fill_reg;
    logic [7:0]       count_reg;
    logic [3:0]       cc_reg;
    logic             usf_reg;
    logic [PID_W-1:0] pid_reg;

    logic [7:0]       pay_mem [BODY_LEN];
    logic [7:0]       rd_data_reg;

    // packet generator
    logic             busy_reg;
    logic [7:0]       pos_reg;
    logic [7:0]       pay_start_reg;
    logic [7:0]       off_reg;
    logic [7:0]       adapt_reg;
    logic             full_reg;
    logic             pusi_reg;
    logic             last_reg;
    logic [3:0]       gcc_reg;

    logic             s1_valid_reg;
    logic             s1_mem_reg;
    logic [7:0]       s1_const_reg;
    logic             s1_eop_reg;
    logic             s1_last_reg;

    logic [7:0]       d_cnt;
    logic [7:0]       d_base;
    logic             d_pusi;
    logic [7:0]       d_start;
    logic             gen_adv;
    logic             pos_mem;
    logic [7:0]       gen_const;
    logic [7:0]       rd_addr;
    logic             at_last;

    always_ff @(posedge clk)
    begin
        if (cmd.win_write)
        begin
            win_reg[fill_reg[1:0]] <= in_byte;
        end
        else if (cmd.push)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            pay_mem[count_reg] <= win_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && gen_adv && pos_mem)
        begin
            rd_data_reg <= pay_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= 3'd0;
            count_reg <= 8'd0;
            cc_reg    <= 4'd0;
            usf_reg   <= 1'b1;
            pid_reg   <= '0;
        end
        else
        begin
            if (cmd.win_write)
            begin
                fill_reg <= fill_reg + 3'd1;
            end
            else if (cmd.push)
            begin
                fill_reg <= fill_reg - 3'd1;
            end
            if (cmd.clr_count)
            begin
                count_reg <= 8'd0;
            end
            else if (cmd.push)
            begin
                count_reg <= count_reg + 8'd1;
            end
            if (cmd.pkt_start)
            begin
                cc_reg <= cc_reg + 4'd1;
            end
            if (cmd.set_usf)
            begin
                usf_reg <= 1'b1;
            end
            else if (cmd.clr_usf)
            begin
                usf_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                pid_reg <= cfg_wr_data;
            end
        end
    end

    always_comb
    begin
        stat.fill_three  = (fill_reg == 3'd3);
        stat.fill_zero   = (fill_reg == 3'd0);
        stat.count_zero  = (count_reg == 8'd0);
        stat.count_split = (count_reg == SPLIT_COUNT);
        stat.start_code  = (win_reg[0] == ZERO_BYTE) && (win_reg[1] == ZERO_BYTE) &&
                           (win_reg[2] == START_PREFIX) && (win_reg[3][7:5] == AUDIO_ID_TOP);
        stat.gen_busy    = busy_reg;
    end

    // packet descriptor
    always_comb
    begin
        d_cnt  = count_reg;
        d_base = 8'd0;
        d_pusi = usf_reg;
        case (cmd.pkt_kind)
            PK_FULL:
            begin
                d_cnt = BODY_LEN_B;
            end
            PK_FLUSH:
            begin
                d_cnt = count_reg;
            end
            PK_SPLIT_A:
            begin
                d_cnt = SPLIT_A_LEN;
            end
            PK_SPLIT_B:
            begin
                d_cnt  = SPLIT_B_LEN;
                d_base = SPLIT_A_LEN;
                d_pusi = 1'b0;
            end
            default:
            begin
                d_cnt = count_reg;
            end
        endcase
        // payload sits at the end of the packet, after any stuffing
        d_start = PKT_LEN_B - d_cnt;
    end

    assign gen_adv = !s1_valid_reg || byte_ready;
    assign pos_mem = (pos_reg >= pay_start_reg);
    assign rd_addr = pos_reg + off_reg;
    assign at_last = (pos_reg == LAST_POS);

    always_comb
    begin
        case (pos_reg)
            POS_SYNC:     gen_const = SYNC_BYTE;
            POS_HDR1:     gen_const = {1'b0, pusi_reg, 1'b0, pid_reg[12:8]};
            POS_HDR2:     gen_const = pid_reg[7:0];
            POS_HDR3:     gen_const = {full_reg ? AFC_PAYLOAD : AFC_ADAPT_PAYLOAD, gcc_reg};
            POS_AF_LEN:   gen_const = adapt_reg;
            POS_AF_FLAGS: gen_const = ZERO_BYTE;
            default:      gen_const = STUFF_BYTE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pkt_start)
        begin
            pay_start_reg <= d_start;
            off_reg       <= d_base - d_start;
            adapt_reg     <= ADAPT_BASE - d_cnt;
            full_reg      <= (d_cnt == BODY_LEN_B);
            pusi_reg      <= d_pusi;
            last_reg      <= cmd.pkt_last;
            gcc_reg       <= cc_reg;
        end
        if (busy_reg && gen_adv)
        begin
            s1_mem_reg   <= pos_mem;
            s1_const_reg <= gen_const;
            s1_eop_reg   <= at_last;
            s1_last_reg  <= at_last && last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            pos_reg      <= 8'd0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.pkt_start)
            begin
                busy_reg <= 1'b1;
                pos_reg  <= POS_SYNC;
            end
            else if (busy_reg && gen_adv)
            begin
                pos_reg <= pos_reg + 8'd1;
                if (at_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (gen_adv)
            begin
                s1_valid_reg <= busy_reg;
            end
        end
    end

    always_comb
    begin
        byte_out.valid = s1_valid_reg;
        byte_out.data  = s1_mem_reg ? rd_data_reg : s1_const_reg;
        byte_out.eop   = s1_eop_reg;
        byte_out.last  = s1_last_reg;
    end

endmodule

FILE: rtl/ptsp_wordpack.sv
// ----------------------------------------------------------------------------
// ptsp_wordpack
// Packs packet bytes into 64-bit words and holds the outgoing word.
// ----------------------------------------------------------------------------
module ptsp_wordpack (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ptsp_pkg::ptsp_byte_t          byte_in,
    output logic                          byte_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ptsp_pkg::WORD_W-1:0]   out_word,
    output logic [3:0]                    out_bv,
    output logic                          out_eop,
    output logic                          out_last
);
    import ptsp_pkg::*;

    logic [55:0]       acc_reg;
    logic [2:0]        idx_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic [3:0]        out_bv_reg;
    logic              out_eop_reg;
    logic              out_last_reg;

    logic out_free;
    logic completing;
    logic take;

    assign out_free   = !out_valid_reg || out_ready;
    assign completing = (idx_reg == 3'd7) || byte_in.eop;
    assign byte_ready = out_free || !completing;
    assign take       = byte_in.valid && byte_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (take && completing)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= 3'd0;
            end
            else if (take)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !completing)
        begin
            acc_reg <= {acc_reg[47:0], byte_in.data};
        end
        if (take && completing)
        begin
            // packet tail word: four bytes in the upper half, lower half zero
            if (byte_in.eop)
            begin
                out_word_reg <= {acc_reg[23:0], byte_in.data, 32'h0};
                out_bv_reg   <= BV_TAIL;
            end
            else
            begin
                out_word_reg <= {acc_reg, byte_in.data};
                out_bv_reg   <= BV_FULL;
            end
            out_eop_reg  <= byte_in.eop;
            out_last_reg <= byte_in.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_bv    = out_bv_reg;
    assign out_eop   = out_eop_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: rtl/pes_to_ts_packetizer.sv
// ----------------------------------------------------------------------------
// pes_to_ts_packetizer: audio PES byte stream to 188-byte transport packets.
// A byte that leaves the window partly filled is only written into it; one that
// fills it is also checked for a start code, which first flushes any pending
// payload, and is then pushed to the payload RAM. The generator reads one payload
// RAM byte per cycle unless the output stalls. Async reset clears counters and
// window fill, sets unit start, PID 0; RAM is not cleared.
// ----------------------------------------------------------------------------
module pes_to_ts_packetizer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]                         s_axis_tuser,   // [0] action
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [63:0] packet_word, [67:64] bytes_valid, [68] end_of_packet, [71:69] zero
    output logic [ptsp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tlast,   // last_of_run
    input  logic                               cfg_wr_en,
    input  logic [ptsp_pkg::PID_W-1:0]         cfg_wr_data     // stream_pid
);
    import ptsp_pkg::*;

    ptsp_cmd_t         cmd;
    ptsp_stat_t        stat;
    ptsp_byte_t        gen_byte;
    logic              gen_ready;
    logic [WORD_W-1:0] out_word;
    logic [3:0]        out_bv;
    logic              out_eop;

    ptsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tuser[0]),
        .in_ready  (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ptsp_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (s_axis_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .byte_out    (gen_byte),
        .byte_ready  (gen_ready)
    );

    ptsp_wordpack u_wordpack (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (gen_byte),
        .byte_ready (gen_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_word   (out_word),
        .out_bv     (out_bv),
        .out_eop    (out_eop),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_eop, out_bv, out_word};

endmodule

FILE: rtl/ptsp_checker.sv
// ----------------------------------------------------------------------------
// ptsp_checker
// Port-level checks of the packetizer output word stream.
// ----------------------------------------------------------------------------
`include "pes_to_ts_packetizer_defines.svh"

module ptsp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ptsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tlast
);
    import ptsp_pkg::*;

    logic at_start_reg;
    logic at_start_next;

    // next delivered word opens a packet
    always_comb
    begin
        at_start_next = at_start_reg;
        if (m_axis_tvalid && m_axis_tready)
        begin
            at_start_next = m_axis_tdata[68];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg <= 1'b1;
        end
        else
        begin
            at_start_reg <= at_start_next;
        end
    end

    `PTSP_ASSERT_NXT(a_hold_stalled, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled word changed")
    `PTSP_ASSERT_IMP(a_word_shape, m_axis_tvalid, m_axis_tdata[68] ? ((m_axis_tdata[67:64] == BV_TAIL) && (m_axis_tdata[31:0] == 32'h0)) : (m_axis_tdata[67:64] == BV_FULL), "bad byte count for word")
    `PTSP_ASSERT_IMP(a_run_ends_packet, m_axis_tvalid && m_axis_tlast, m_axis_tdata[68], "run ended inside a packet")
    `PTSP_ASSERT_IMP(a_sync_first, m_axis_tvalid && at_start_reg, m_axis_tdata[63:56] == SYNC_BYTE, "packet without sync byte")

endmodule

bind pes_to_ts_packetizer ptsp_checker u_ptsp_checker (.*);
